// File: src/vn_pkg.sv
// Shared widths, mode codes and lane types for the vector normalize pipeline.
// Used by every module under src; depends on nothing.
package vn_pkg;

  localparam int CompBits     = 16;
  localparam int UnitFracBits = 14;
  localparam int Lanes        = 4;

  localparam int RootW = CompBits + 1;
  localparam int SqW   = 2 * CompBits - 1;
  localparam int SumW  = 2 * CompBits + 1;
  localparam int RemW  = RootW + 3;
  localparam int QuoW  = UnitFracBits + 1;
  localparam int UnitW = UnitFracBits + 2;

  localparam logic [1:0] MODE_2D = 2'd0;
  localparam logic [1:0] MODE_3D = 2'd1;
  localparam logic [1:0] MODE_4D = 2'd2;

  typedef struct packed {
    logic                neg;
    logic [CompBits-1:0] mag;
  } lane_t;

  typedef lane_t [Lanes-1:0] lanes_t;

endpackage

// File: src/vn_square.sv
// Front end: absolute values, squares and the sum of squares, three stages.
// Depends on vn_pkg.
module vn_square (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [1:0]                                  mode_i,
  input  logic [vn_pkg::Lanes-1:0][vn_pkg::CompBits-1:0] comp_i,
  output logic                                        valid_o,
  output logic [vn_pkg::SumW-1:0]                     sum_o,
  output vn_pkg::lanes_t                              lanes_o
);
  import vn_pkg::*;

  logic [2:0]         valid_q;
  lanes_t             lanes1_d, lanes1_q, lanes2_q, lanes3_q;
  logic [SqW-1:0]     sq_q [Lanes];
  logic [2*CompBits-1:0] prod [Lanes];
  logic [SumW-1:0]    sum_q;

  always_comb begin
    logic used;
    for (int l = 0; l < Lanes; l++) begin
      used = (l < 2) || (l == 2 && mode_i != MODE_2D) ||
             (l == 3 && mode_i != MODE_2D && mode_i != MODE_3D);
      lanes1_d[l].neg = used & comp_i[l][CompBits-1];
      if (!used) begin
        lanes1_d[l].mag = '0;
      end else if (comp_i[l][CompBits-1]) begin
        lanes1_d[l].mag = CompBits'(~comp_i[l] + 1'b1);
      end else begin
        lanes1_d[l].mag = comp_i[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      prod[l] = lanes1_q[l].mag * lanes1_q[l].mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes1_q <= lanes1_d;
      lanes2_q <= lanes1_q;
      lanes3_q <= lanes2_q;
      for (int l = 0; l < Lanes; l++) begin
        sq_q[l] <= prod[l][SqW-1:0];
      end
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]) + SumW'(sq_q[3]);
    end
  end

  assign valid_o = valid_q[2];
  assign sum_o   = sum_q;
  assign lanes_o = lanes3_q;

endmodule

// File: src/vn_sqrt.sv
// Integer square root, one result bit per pipeline stage (digit recurrence).
// Depends on vn_pkg.
module vn_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [vn_pkg::SumW-1:0] sum_i,
  input  vn_pkg::lanes_t          lanes_i,
  output logic                    valid_o,
  output logic [vn_pkg::RootW-1:0] root_o,
  output vn_pkg::lanes_t          lanes_o
);
  import vn_pkg::*;

  localparam int PadW = 2 * RootW;

  logic [RootW-1:0] valid_q;
  logic [PadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  lanes_t           lanes_q [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_step
    logic [PadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic [RootW-1:0] root_in;
    lanes_t           lanes_in;
    logic             v_in;

    if (j == 0) begin : g_first
      assign rad_in   = PadW'(sum_i);
      assign rem_in   = '0;
      assign root_in  = '0;
      assign lanes_in = lanes_i;
      assign v_in     = valid_i;
    end else begin : g_next
      assign rad_in   = rad_q[j-1];
      assign rem_in   = rem_q[j-1];
      assign root_in  = root_q[j-1];
      assign lanes_in = lanes_q[j-1];
      assign v_in     = valid_q[j-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], rad_in[2*(RootW-1-j)+1 -: 2]};
    assign trial  = RemW'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]   <= rad_in;
        lanes_q[j] <= lanes_in;
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign lanes_o = lanes_q[RootW-1];

endmodule

// File: src/vn_div.sv
// Four restoring dividers side by side, one quotient bit per stage, giving
// |component| * 2^UnitFracBits / magnitude. Depends on vn_pkg.
module vn_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [vn_pkg::RootW-1:0] root_i,
  input  vn_pkg::lanes_t           lanes_i,
  output logic                     valid_o,
  output logic [vn_pkg::RootW-1:0] root_o,
  output logic [vn_pkg::Lanes-1:0] neg_o,
  output logic [vn_pkg::Lanes-1:0][vn_pkg::QuoW-1:0] quo_o
);
  import vn_pkg::*;

  logic [QuoW-1:0]                 valid_q;
  logic [RootW-1:0]                root_q [QuoW];
  logic [Lanes-1:0]                neg_q  [QuoW];
  logic [Lanes-1:0]                lsb_q  [QuoW];
  logic [Lanes-1:0][RootW-1:0]     rem_q  [QuoW];
  logic [Lanes-1:0][QuoW-1:0]      quo_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [RootW-1:0]            div_in;
    logic [Lanes-1:0]            neg_in, lsb_in;
    logic [Lanes-1:0][RootW-1:0] rem_in;
    logic [Lanes-1:0][QuoW-1:0]  quo_in;
    logic                        v_in;

    if (k == 0) begin : g_first
      // The upper dividend bits are |component| >> 1; its low bit enters first.
      always_comb begin
        for (int l = 0; l < Lanes; l++) begin
          neg_in[l] = lanes_i[l].neg;
          lsb_in[l] = lanes_i[l].mag[0];
          rem_in[l] = RootW'(lanes_i[l].mag >> 1);
          quo_in[l] = '0;
        end
      end
      assign div_in = root_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign neg_in = neg_q[k-1];
      assign lsb_in = '0;
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign div_in = root_q[k-1];
      assign v_in   = valid_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      logic [RootW:0] part;
      if (en_i) begin
        root_q[k] <= div_in;
        neg_q[k]  <= neg_in;
        lsb_q[k]  <= lsb_in;
        for (int l = 0; l < Lanes; l++) begin
          part = {rem_in[l], lsb_in[l]};
          if (part >= {1'b0, div_in}) begin
            rem_q[k][l] <= RootW'(part - {1'b0, div_in});
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b1};
          end else begin
            rem_q[k][l] <= part[RootW-1:0];
            quo_q[k][l] <= {quo_in[l][QuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign root_o  = root_q[QuoW-1];
  assign neg_o   = neg_q[QuoW-1] ^ lsb_q[QuoW-1] ^ lsb_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];

endmodule

// File: src/vector_normalize.sv
// Top level of the vector normalize pipeline: squares, root, dividers, output register.
// Depends on vn_pkg, vn_square, vn_sqrt and vn_div.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid_i/in_ready_o | mode_i, comp_x_i, comp_y_i, comp_z_i, comp_w_i
//   output  | out_valid_o/out_ready_i | unit_x_o .. unit_w_o, magnitude_o,
//           |                       | zero_length_o
//
// One transaction per cycle while the output is taken; each passes the square stages,
// the root recurrence (one bit per stage), the dividers (one quotient bit per stage)
// and the output register. The whole pipeline advances together; it holds while a result
// waits unread. Reset clears only the valid bits; there is no clearing pass.
module vector_normalize (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic signed [vn_pkg::CompBits-1:0] comp_x_i,
  input  logic signed [vn_pkg::CompBits-1:0] comp_y_i,
  input  logic signed [vn_pkg::CompBits-1:0] comp_z_i,
  input  logic signed [vn_pkg::CompBits-1:0] comp_w_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [vn_pkg::UnitW-1:0] unit_x_o,
  output logic signed [vn_pkg::UnitW-1:0] unit_y_o,
  output logic signed [vn_pkg::UnitW-1:0] unit_z_o,
  output logic signed [vn_pkg::UnitW-1:0] unit_w_o,
  output logic [vn_pkg::RootW-1:0]    magnitude_o,
  output logic                        zero_length_o
);
  import vn_pkg::*;

  logic                        en;
  logic                        sq_valid, rt_valid, dv_valid;
  logic [SumW-1:0]             sq_sum;
  lanes_t                      sq_lanes, rt_lanes;
  logic [RootW-1:0]            rt_root, dv_root;
  logic [Lanes-1:0]            dv_neg;
  logic [Lanes-1:0][QuoW-1:0]  dv_quo;
  logic [Lanes-1:0][CompBits-1:0] comps;

  logic                        out_valid_q;
  logic [Lanes-1:0][UnitW-1:0] unit_d, unit_q;
  logic [RootW-1:0]            mag_q;
  logic                        zero_q;

  assign en         = out_ready_i || !out_valid_q;
  assign in_ready_o = en;
  assign comps      = {comp_w_i, comp_z_i, comp_y_i, comp_x_i};

  vn_square u_square (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .mode_i, .comp_i(comps),
    .valid_o(sq_valid), .sum_o(sq_sum), .lanes_o(sq_lanes)
  );

  vn_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid), .sum_i(sq_sum),
    .lanes_i(sq_lanes), .valid_o(rt_valid), .root_o(rt_root), .lanes_o(rt_lanes)
  );

  vn_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rt_valid), .root_i(rt_root),
    .lanes_i(rt_lanes), .valid_o(dv_valid), .root_o(dv_root), .neg_o(dv_neg),
    .quo_o(dv_quo)
  );

  // A zero length makes every divider step succeed, so its quotients are forced off.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (dv_root == '0) begin
        unit_d[l] = '0;
      end else if (dv_neg[l]) begin
        unit_d[l] = UnitW'(~UnitW'(dv_quo[l]) + 1'b1);
      end else begin
        unit_d[l] = UnitW'(dv_quo[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      mag_q  <= dv_root;
      zero_q <= (dv_root == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign unit_w_o      = unit_q[3];
  assign magnitude_o   = mag_q;
  assign zero_length_o = zero_q;

`ifndef NO_ASSERTIONS
  a_zero_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zero_length_o == (magnitude_o == '0)))
    else $error("zero_length disagrees with magnitude");

  a_zero_units : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |->
      (unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 && unit_w_o == '0))
    else $error("nonzero unit component for a zero-length vector");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unit_x_o <= $signed(UnitW'(1 << UnitFracBits)) &&
                     unit_x_o >= -$signed(UnitW'(1 << UnitFracBits))))
    else $error("unit_x out of unit range");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(magnitude_o)))
    else $error("pending result changed during a stall");
`endif

endmodule
